[hdl/sce_pkg.sv]
// Shared types and fixed constants of the sample covariance estimator.
// Used by the divider and the top level; it depends on nothing else.

package sce_pkg;

    // Port and field widths fixed by the stream format.
    localparam int IN_BITS        = 16;
    localparam int IN_TDATA_BITS  = 32;
    localparam int OUT_TDATA_BITS = 80;
    localparam int IDX_OUT_BITS   = 3;
    localparam int REAL_BITS      = 34;
    localparam int IMAG_BITS      = 33;

    // Configuration port and register widths.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int ELEM_BITS      = 4;
    localparam int COUNT_BITS     = 16;
    localparam int GAMMA_BITS     = 16;

    // Register reset values.
    localparam int ELEM_RESET  = 8;
    localparam int COUNT_RESET = 16;
    localparam int GAMMA_RESET = 655;

    // Loading arithmetic: the gamma product wraps at 64 bits, then drops the
    // Q16 fraction. The trace is split for two narrow partial products.
    localparam int PROD_BITS   = 64;
    localparam int LOAD_SHIFT  = 16;
    localparam int LOAD_BITS   = PROD_BITS - LOAD_SHIFT;
    localparam int TRACE_SPLIT = 26;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ELEMENT_COUNT  = 2'd0,
        CFG_SNAPSHOT_COUNT = 2'd1,
        CFG_LOADING_GAMMA  = 2'd2
    } t_cfg_index;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MAC,
        S_MAC_DRAIN,
        S_TR_RD,
        S_TR_WT,
        S_TR_DIV,
        S_LD_MUL,
        S_LD_SUM,
        S_LD_DIV,
        S_EN_RD,
        S_EN_WT,
        S_EN_DRE,
        S_EN_DIM,
        S_EN_OUT
    } t_state;

    // Status of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

[hdl/sce_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the snapshot buffer and the accumulator matrix.

module sce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/sce_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sce_pkg for the status struct.

module sce_div #(
    parameter int DIVIDEND_BITS = 49,
    parameter int DIVISOR_BITS  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DIVIDEND_BITS-1:0] i_dividend,
    input  logic [DIVISOR_BITS-1:0]  i_divisor,
    output sce_pkg::t_div_status     o_status,
    output logic [DIVIDEND_BITS-1:0] o_quotient
);

    localparam int CW = $clog2(DIVIDEND_BITS + 1);

    logic                     r_busy;
    logic                     r_done;
    logic [CW-1:0]            r_cnt;
    logic [DIVIDEND_BITS-1:0] r_quo;
    logic [DIVISOR_BITS-1:0]  r_rem;
    logic [DIVISOR_BITS-1:0]  r_div;

    logic [DIVISOR_BITS:0] rem_sh;
    logic [DIVISOR_BITS:0] rem_sub;
    logic                  fits;

    // One trial subtraction of the shifted remainder.
    always_comb begin
        rem_sh  = {r_rem, r_quo[DIVIDEND_BITS-1]};
        fits    = (rem_sh >= {1'b0, r_div});
        rem_sub = rem_sh - {1'b0, r_div};
    end

    // Step counter and handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIVIDEND_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend shifts out at the top while quotient bits shift in below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub[DIVISOR_BITS-1:0] : rem_sh[DIVISOR_BITS-1:0];
            r_quo <= {r_quo[DIVIDEND_BITS-2:0], fits};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;

endmodule

[hdl/sample_covariance_estimator.sv]
// Sample covariance estimator with diagonal loading, top level.
// Depends on sce_pkg, sce_ram (buffer and accumulators) and sce_div.
//
// Samples arrive on the s_axis channel, one array element per request
// (real part in the low half of tdata). Every M requests form a snapshot.
// The request that closes a snapshot starts a multiply-accumulate pass
// through one complex MAC unit, one matrix entry per cycle; tready stays
// low until the pass drains or, after K snapshots, until the final entry
// is loaded. The estimate uses one shared 1-bit-per-cycle divider (D =
// max(2*SAMPLE_BITS+17, 48) steps): the trace takes M divisions, the
// loading term one unless gamma or the trace is zero, and each of the M*M
// entries two (real and imaginary).
// Entries leave on m_axis in row order through an output register; tlast
// marks the final entry. A stall on m_axis holds the sequencer before the
// next entry; after the final entry is loaded the block accepts samples
// again while that entry waits. Configuration writes on the cfg channel
// are always ready and must be issued while the block is idle.
// Reset restores register defaults and clears the accumulators at once.

module sample_covariance_estimator #(
    parameter int MAX_ELEMENTS = 8,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // Sample input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: sample_real [15:0], sample_imag [31:16]
    input  logic [31:0] i_s_axis_tdata,
    // Covariance entry output stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: row_index [2:0], col_index [5:3], entry_real [39:6],
    //        entry_imag [72:40], zero [79:73]
    output logic [79:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    localparam int EB    = sce_pkg::ELEM_BITS;
    localparam int KB    = sce_pkg::COUNT_BITS;
    localparam int GB    = sce_pkg::GAMMA_BITS;
    localparam int IB    = sce_pkg::IN_BITS;
    localparam int OIB   = sce_pkg::IDX_OUT_BITS;
    localparam int RB    = sce_pkg::REAL_BITS;
    localparam int MB    = sce_pkg::IMAG_BITS;
    localparam int PB    = sce_pkg::PROD_BITS;
    localparam int LSH   = sce_pkg::LOAD_SHIFT;
    localparam int LB    = sce_pkg::LOAD_BITS;
    localparam int SPL   = sce_pkg::TRACE_SPLIT;
    localparam int OTB   = sce_pkg::OUT_TDATA_BITS;

    localparam int IW        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int GRID      = 1 << (2 * IW);
    localparam int BUF_BITS  = 2 * SAMPLE_BITS;
    localparam int PRD_BITS  = 2 * SAMPLE_BITS;
    localparam int ACC_BITS  = 2 * SAMPLE_BITS + 17;
    localparam int DIV_BITS  = (ACC_BITS > LB) ? ACC_BITS : LB;
    localparam int TR_BITS   = ACC_BITS + IW;
    localparam int SUM_BITS  = DIV_BITS + 2;
    localparam int QS_BITS   = DIV_BITS + 1;
    localparam int PLO_BITS  = GB + SPL;
    localparam int PHI_BITS  = GB + TR_BITS - SPL;
    localparam int PAD_BITS  = OTB - 2 * OIB - RB - MB;

    localparam logic [EB-1:0] MAX_M = EB'(MAX_ELEMENTS);

    // Saturation bounds of the output fields.
    localparam logic signed [SUM_BITS-1:0] RE_HI =
        {{(SUM_BITS - RB + 1){1'b0}}, {(RB - 1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] RE_LO =
        {{(SUM_BITS - RB + 1){1'b1}}, {(RB - 1){1'b0}}};
    localparam logic signed [QS_BITS-1:0] IM_HI =
        {{(QS_BITS - MB + 1){1'b0}}, {(MB - 1){1'b1}}};
    localparam logic signed [QS_BITS-1:0] IM_LO =
        {{(QS_BITS - MB + 1){1'b1}}, {(MB - 1){1'b0}}};

    // Configuration registers.
    logic [EB-1:0] r_element_count;
    logic [KB-1:0] r_snapshot_count;
    logic [GB-1:0] r_gamma;

    // Sequencer and snapshot bookkeeping.
    sce_pkg::t_state r_state;
    sce_pkg::t_state n_state;
    logic [IW-1:0]   r_pos;
    logic [KB-1:0]   r_snaps;
    logic            r_emit;
    logic [IW-1:0]   r_i;
    logic [IW-1:0]   r_j;

    // MAC pipeline.
    logic                        r_s1_v;
    logic [2*IW-1:0]             r_s1_addr;
    logic                        r_s2_v;
    logic [2*IW-1:0]             r_s2_addr;
    logic signed [PRD_BITS-1:0]  r_pr_rr;
    logic signed [PRD_BITS-1:0]  r_pr_ii;
    logic signed [PRD_BITS-1:0]  r_pr_ir;
    logic signed [PRD_BITS-1:0]  r_pr_ri;
    logic signed [ACC_BITS-1:0]  r_s2_acc_re;
    logic signed [ACC_BITS-1:0]  r_s2_acc_im;

    // Accumulator valid bits and the registered valid of the read entry.
    logic [GRID-1:0] r_acc_ok;
    logic            r_rd_ok;

    // Estimate arithmetic.
    logic [TR_BITS-1:0]         r_trace;
    logic [PLO_BITS-1:0]        r_p_lo;
    logic [PHI_BITS-1:0]        r_p_hi;
    logic [LB-1:0]              r_load;
    logic signed [QS_BITS-1:0]  r_q_re;
    logic [RB-1:0]              r_pend_re;
    logic [MB-1:0]              r_pend_im;

    // Output register.
    logic           r_out_valid;
    logic [OIB-1:0] r_out_row;
    logic [OIB-1:0] r_out_col;
    logic [RB-1:0]  r_out_re;
    logic [MB-1:0]  r_out_im;
    logic           r_out_last;

    // Combinational signals.
    logic [EB-1:0]   m_eff;
    logic [KB-1:0]   k_eff;
    logic            s_accept;
    logic            pos_last;
    logic [KB-1:0]   snaps_inc;
    logic            emit_now;
    logic            i_last;
    logic            j_last;
    logic            entry_last;
    logic            drained;
    logic            out_free;
    logic            out_load;
    logic            load_skip;

    logic [BUF_BITS-1:0]     buf_wdata;
    logic [BUF_BITS-1:0]     buf_a_rdata;
    logic [BUF_BITS-1:0]     buf_b_rdata;
    logic [2*IW-1:0]         acc_raddr;
    logic [2*ACC_BITS-1:0]   acc_rdata;
    logic [2*ACC_BITS-1:0]   acc_wdata;
    logic signed [ACC_BITS-1:0] acc_rd_re;
    logic signed [ACC_BITS-1:0] acc_rd_im;
    logic signed [ACC_BITS-1:0] new_re;
    logic signed [ACC_BITS-1:0] new_im;
    logic [ACC_BITS-1:0]     mag_re;
    logic [ACC_BITS-1:0]     mag_im;

    logic signed [SAMPLE_BITS-1:0] a_re;
    logic signed [SAMPLE_BITS-1:0] a_im;
    logic signed [SAMPLE_BITS-1:0] b_re;
    logic signed [SAMPLE_BITS-1:0] b_im;

    logic [PB-1:0]              prod_full;
    logic signed [QS_BITS-1:0]  q_im;
    logic signed [SUM_BITS-1:0] re_sum;

    logic                  div_start;
    logic [DIV_BITS-1:0]   div_dividend;
    logic [KB-1:0]         div_divisor;
    sce_pkg::t_div_status  div_status;
    logic [DIV_BITS-1:0]   div_quo;

    // Effective element and snapshot counts.
    always_comb begin
        if (r_element_count == '0) begin
            m_eff = EB'(1);
        end else if (r_element_count > MAX_M) begin
            m_eff = MAX_M;
        end else begin
            m_eff = r_element_count;
        end
        k_eff = (r_snapshot_count == '0) ? KB'(1) : r_snapshot_count;
    end

    // Handshake and loop position decodes.
    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == sce_pkg::S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign pos_last        = (EB'(r_pos) + EB'(1)) >= m_eff;
    assign snaps_inc       = r_snaps + KB'(1);
    assign emit_now        = (snaps_inc >= k_eff);
    assign i_last          = (EB'(r_i) + EB'(1)) == m_eff;
    assign j_last          = (EB'(r_j) + EB'(1)) == m_eff;
    assign entry_last      = i_last && j_last;
    assign drained         = !r_s1_v && !r_s2_v;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign out_load        = (r_state == sce_pkg::S_EN_OUT) && out_free;
    assign load_skip       = (r_gamma == '0) || (r_trace == '0);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_element_count  <= EB'(sce_pkg::ELEM_RESET);
            r_snapshot_count <= KB'(sce_pkg::COUNT_RESET);
            r_gamma          <= GB'(sce_pkg::GAMMA_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (sce_pkg::t_cfg_index'(i_cfg_index))
                sce_pkg::CFG_ELEMENT_COUNT: begin
                    r_element_count <= i_cfg_data[EB-1:0];
                end
                sce_pkg::CFG_SNAPSHOT_COUNT: begin
                    r_snapshot_count <= i_cfg_data[KB-1:0];
                end
                sce_pkg::CFG_LOADING_GAMMA: begin
                    r_gamma <= i_cfg_data[GB-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Snapshot buffer: two copies so that x_i and x_j are read together.
    assign buf_wdata = {i_s_axis_tdata[IB +: SAMPLE_BITS], i_s_axis_tdata[SAMPLE_BITS-1:0]};

    sce_ram #(
        .WIDTH (BUF_BITS),
        .DEPTH (MAX_ELEMENTS)
    ) u_buf_row (
        .i_clk   (i_clk),
        .i_we    (s_accept),
        .i_waddr (r_pos),
        .i_wdata (buf_wdata),
        .i_raddr (r_i),
        .o_rdata (buf_a_rdata)
    );

    sce_ram #(
        .WIDTH (BUF_BITS),
        .DEPTH (MAX_ELEMENTS)
    ) u_buf_col (
        .i_clk   (i_clk),
        .i_we    (s_accept),
        .i_waddr (r_pos),
        .i_wdata (buf_wdata),
        .i_raddr (r_j),
        .o_rdata (buf_b_rdata)
    );

    // Accumulator matrix, slot {row, col}, imaginary part in the upper half.
    assign acc_raddr = (r_state == sce_pkg::S_TR_RD || r_state == sce_pkg::S_TR_WT ||
                        r_state == sce_pkg::S_TR_DIV) ? {r_i, r_i} : {r_i, r_j};

    sce_ram #(
        .WIDTH (2 * ACC_BITS),
        .DEPTH (GRID)
    ) u_acc (
        .i_clk   (i_clk),
        .i_we    (r_s2_v),
        .i_waddr (r_s2_addr),
        .i_wdata (acc_wdata),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rdata)
    );

    // A slot not written since the last clear reads as zero.
    assign acc_rd_re = r_rd_ok ? acc_rdata[ACC_BITS-1:0] : '0;
    assign acc_rd_im = r_rd_ok ? acc_rdata[2*ACC_BITS-1:ACC_BITS] : '0;

    always_ff @(posedge i_clk) begin
        r_rd_ok <= r_acc_ok[acc_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_ok <= '0;
        end else if (out_load && entry_last) begin
            r_acc_ok <= '0;
        end else if (r_s2_v) begin
            r_acc_ok[r_s2_addr] <= 1'b1;
        end
    end

    // MAC stage 1: four partial products of x_i * conj(x_j).
    assign a_re = buf_a_rdata[SAMPLE_BITS-1:0];
    assign a_im = buf_a_rdata[BUF_BITS-1:SAMPLE_BITS];
    assign b_re = buf_b_rdata[SAMPLE_BITS-1:0];
    assign b_im = buf_b_rdata[BUF_BITS-1:SAMPLE_BITS];

    always_ff @(posedge i_clk) begin
        r_pr_rr     <= a_re * b_re;
        r_pr_ii     <= a_im * b_im;
        r_pr_ir     <= a_im * b_re;
        r_pr_ri     <= a_re * b_im;
        r_s2_acc_re <= acc_rd_re;
        r_s2_acc_im <= acc_rd_im;
        r_s2_addr   <= r_s1_addr;
        r_s1_addr   <= {r_i, r_j};
    end

    // MAC stage 2: add into the accumulator slot.
    assign new_re    = r_s2_acc_re + ACC_BITS'(r_pr_rr) + ACC_BITS'(r_pr_ii);
    assign new_im    = r_s2_acc_im + ACC_BITS'(r_pr_ir) - ACC_BITS'(r_pr_ri);
    assign acc_wdata = {new_im, new_re};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= (r_state == sce_pkg::S_MAC);
            r_s2_v <= r_s1_v;
        end
    end

    // Magnitudes for division toward zero.
    assign mag_re = acc_rd_re[ACC_BITS-1] ? ACC_BITS'(-acc_rd_re) : acc_rd_re;
    assign mag_im = acc_rd_im[ACC_BITS-1] ? ACC_BITS'(-acc_rd_im) : acc_rd_im;

    // Loading product, wrapped to 64 bits as the Q16 scaling expects.
    assign prod_full = PB'(r_p_lo) + (PB'(r_p_hi) << SPL);

    // Imaginary quotient with sign restored, and the loaded real part.
    always_comb begin
        q_im = acc_rd_im[ACC_BITS-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        re_sum = SUM_BITS'(r_q_re);
        if (r_i == r_j) begin
            re_sum = re_sum + $signed({2'b00, DIV_BITS'(r_load)});
        end
    end

    // Shared divider.
    sce_div #(
        .DIVIDEND_BITS (DIV_BITS),
        .DIVISOR_BITS  (KB)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_status   (div_status),
        .o_quotient (div_quo)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sce_pkg::S_IDLE: begin
                if (s_accept && pos_last) begin
                    n_state = sce_pkg::S_MAC;
                end
            end
            sce_pkg::S_MAC: begin
                if (entry_last) begin
                    n_state = sce_pkg::S_MAC_DRAIN;
                end
            end
            sce_pkg::S_MAC_DRAIN: begin
                if (drained) begin
                    n_state = r_emit ? sce_pkg::S_TR_RD : sce_pkg::S_IDLE;
                end
            end
            sce_pkg::S_TR_RD: begin
                n_state = sce_pkg::S_TR_WT;
            end
            sce_pkg::S_TR_WT: begin
                n_state = sce_pkg::S_TR_DIV;
            end
            sce_pkg::S_TR_DIV: begin
                if (div_status.done) begin
                    n_state = i_last ? sce_pkg::S_LD_MUL : sce_pkg::S_TR_RD;
                end
            end
            sce_pkg::S_LD_MUL: begin
                n_state = sce_pkg::S_LD_SUM;
            end
            sce_pkg::S_LD_SUM: begin
                n_state = load_skip ? sce_pkg::S_EN_RD : sce_pkg::S_LD_DIV;
            end
            sce_pkg::S_LD_DIV: begin
                if (div_status.done) begin
                    n_state = sce_pkg::S_EN_RD;
                end
            end
            sce_pkg::S_EN_RD: begin
                n_state = sce_pkg::S_EN_WT;
            end
            sce_pkg::S_EN_WT: begin
                n_state = sce_pkg::S_EN_DRE;
            end
            sce_pkg::S_EN_DRE: begin
                if (div_status.done) begin
                    n_state = sce_pkg::S_EN_DIM;
                end
            end
            sce_pkg::S_EN_DIM: begin
                if (div_status.done) begin
                    n_state = sce_pkg::S_EN_OUT;
                end
            end
            sce_pkg::S_EN_OUT: begin
                if (out_free) begin
                    n_state = entry_last ? sce_pkg::S_IDLE : sce_pkg::S_EN_RD;
                end
            end
            default: begin
                n_state = sce_pkg::S_IDLE;
            end
        endcase
    end

    // Divider requests issued by the sequencer.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = DIV_BITS'(mag_re);
        div_divisor  = k_eff;
        unique case (r_state)
            sce_pkg::S_TR_WT, sce_pkg::S_EN_WT: begin
                div_start = 1'b1;
            end
            sce_pkg::S_LD_SUM: begin
                div_start    = !load_skip;
                div_dividend = DIV_BITS'(prod_full[PB-1:LSH]);
                div_divisor  = KB'(m_eff);
            end
            sce_pkg::S_EN_DRE: begin
                div_start    = div_status.done;
                div_dividend = DIV_BITS'(mag_im);
            end
            default: begin
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sce_pkg::S_IDLE;
            r_pos   <= '0;
            r_snaps <= '0;
            r_emit  <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                sce_pkg::S_IDLE: begin
                    if (s_accept) begin
                        if (pos_last) begin
                            r_pos   <= '0;
                            r_snaps <= emit_now ? '0 : snaps_inc;
                            r_emit  <= emit_now;
                            r_i     <= '0;
                            r_j     <= '0;
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end
                end
                sce_pkg::S_MAC: begin
                    if (j_last) begin
                        r_j <= '0;
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                sce_pkg::S_MAC_DRAIN: begin
                    r_i <= '0;
                    r_j <= '0;
                end
                sce_pkg::S_TR_DIV: begin
                    if (div_status.done) begin
                        r_i <= i_last ? '0 : r_i + 1'b1;
                        r_j <= '0;
                    end
                end
                sce_pkg::S_EN_OUT: begin
                    if (out_free) begin
                        if (j_last) begin
                            r_j <= '0;
                            r_i <= r_i + 1'b1;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Estimate datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == sce_pkg::S_MAC_DRAIN) begin
            r_trace <= '0;
        end else if (r_state == sce_pkg::S_TR_DIV && div_status.done) begin
            // Diagonal sums of squared magnitudes are never negative.
            r_trace <= r_trace + TR_BITS'(div_quo);
        end
        if (r_state == sce_pkg::S_LD_MUL) begin
            r_p_lo <= r_gamma * r_trace[SPL-1:0];
            r_p_hi <= r_gamma * r_trace[TR_BITS-1:SPL];
        end
        if (r_state == sce_pkg::S_LD_SUM) begin
            r_load <= '0;
        end else if (r_state == sce_pkg::S_LD_DIV && div_status.done) begin
            r_load <= div_quo[LB-1:0];
        end
        if (r_state == sce_pkg::S_EN_DRE && div_status.done) begin
            r_q_re <= acc_rd_re[ACC_BITS-1] ? -$signed({1'b0, div_quo})
                                            : $signed({1'b0, div_quo});
        end
        if (r_state == sce_pkg::S_EN_DIM && div_status.done) begin
            if (re_sum > RE_HI) begin
                r_pend_re <= RE_HI[RB-1:0];
            end else if (re_sum < RE_LO) begin
                r_pend_re <= RE_LO[RB-1:0];
            end else begin
                r_pend_re <= re_sum[RB-1:0];
            end
            if (q_im > IM_HI) begin
                r_pend_im <= IM_HI[MB-1:0];
            end else if (q_im < IM_LO) begin
                r_pend_im <= IM_LO[MB-1:0];
            end else begin
                r_pend_im <= q_im[MB-1:0];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_row  <= OIB'(r_i);
            r_out_col  <= OIB'(r_j);
            r_out_re   <= r_pend_re;
            r_out_im   <= r_pend_im;
            r_out_last <= entry_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{PAD_BITS{1'b0}}, r_out_im, r_out_re, r_out_col, r_out_row};
    assign o_m_axis_tlast  = r_out_last;

    // The divider is only started when it is free.
    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_status.busy)
        else $error("divider started while busy");

    // Accumulator writes happen only during a multiply-accumulate pass.
    a_write_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> (r_state == sce_pkg::S_MAC || r_state == sce_pkg::S_MAC_DRAIN))
        else $error("accumulator write outside a pass");

    // No sample is taken while the MAC pipeline still holds entries.
    a_ready_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (!r_s1_v && !r_s2_v))
        else $error("sample accepted with MAC pipeline busy");

    // The final entry of a matrix lies on the diagonal.
    a_last_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (r_out_row == r_out_col))
        else $error("last entry off the diagonal");

endmodule
